// File: hdl/ir_ring_ball_direction_macros.svh
`ifndef IR_RING_BALL_DIRECTION_MACROS_SVH
`define IR_RING_BALL_DIRECTION_MACROS_SVH

// Same-cycle check, clocked on clk, off while rst_n is low.
`define IRBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle check: cons must hold on the clock after ante.
`define IRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/irbd_pkg.sv
`timescale 1ns / 1ps
package irbd_pkg;

  localparam int NUM_SENSORS  = 16;
  localparam int READING_BITS = 10;
  localparam int CNT_W        = $clog2(NUM_SENSORS);

  localparam int NUM_W = 10;
  localparam logic [NUM_W-1:0] NUM_RESET = 10'd250;

  localparam int SUM_W  = 32;
  localparam int DIR_W  = 17;
  localparam int PROD_W = READING_BITS + 1 + DIR_W;

  localparam int CORDIC_STEPS = 16;
  localparam int K_W          = $clog2(CORDIC_STEPS);
  localparam int CV_W         = SUM_W + 3;
  localparam int Z_W          = 21;

  localparam int ANG_W       = 16;
  localparam int DIST_W      = 16;
  localparam int ANGLE_MAX   = 25736;
  localparam int ANGLE_ROUND = 4;
  localparam int ANGLE_SHIFT = 3;

  localparam int SQ_W       = 2 * SUM_W;
  localparam int ROOT_W     = SUM_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int ITER_W     = $clog2(SQRT_STEPS);

  localparam int DIV_STEPS = DIST_W;
  localparam int DIV_SHIFT = 23 - DIST_W;
  localparam int DREM_W    = ROOT_W + 1;

  localparam longint Q16_PI      = 205887;
  localparam longint Q16_HALF_PI = 102944;
  localparam longint Q16_TWO_PI  = 411775;
  localparam longint DIR_GAIN    = 19899;

  // atan(2^-k), Q.16
  localparam int ATAN_Q16 [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic [DIR_W-1:0] c;
    logic [DIR_W-1:0] s;
  } dir_t;

  typedef dir_t [NUM_SENSORS-1:0] dir_tab_t;

  // Sensor cos/sin at scale 2^15, built with the same rotation CORDIC the
  // heading math is defined by, so the table is bit exact.
  function automatic dir_tab_t build_dir_tab();
    dir_tab_t tab;
    longint   th;
    longint   x;
    longint   y;
    longint   nx;
    logic     flip;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      th = Q16_HALF_PI -
           ((longint'(i) + 1) * Q16_TWO_PI + NUM_SENSORS / 2) / NUM_SENSORS;
      x    = DIR_GAIN;
      y    = 0;
      flip = 1'b0;
      if (th > Q16_HALF_PI) begin
        th   = th - Q16_PI;
        flip = 1'b1;
      end
      if (th < -Q16_HALF_PI) begin
        th   = th + Q16_PI;
        flip = 1'b1;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (th >= 0) begin
          nx = x - (y >>> k);
          y  = y + (x >>> k);
          th = th - longint'(ATAN_Q16[k]);
        end else begin
          nx = x + (y >>> k);
          y  = y - (x >>> k);
          th = th + longint'(ATAN_Q16[k]);
        end
        x = nx;
      end
      tab[i].c = DIR_W'(flip ? -x : x);
      tab[i].s = DIR_W'(flip ? -y : y);
    end
    return tab;
  endfunction

  localparam dir_tab_t DIR_TAB = build_dir_tab();

  typedef struct packed {
    logic              accum;
    logic              load;
    logic              sq_x;
    logic              sq_y;
    logic              add_sq;
    logic              calc;
    logic              cordic;
    logic              prep;
    logic              div;
    logic              emit;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/ir_ring_ball_direction.sv
// Input: a reading is taken whenever the controller is idle; from the frame's last
// reading until its result is loaded into the output register, in_stall is high.
// The 32-step square root and the 16-step divider share one iteration counter;
// the next frame's readings wait until the previous frame's result is emitted.
// Reset (rst_n low, synchronous): sums and sensor index cleared, numerator 250,
// no result pending.
`timescale 1ns / 1ps
module ir_ring_ball_direction (
  input  logic                              clk,
  input  logic                              rst_n,
  // sensor readings, ring order
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [irbd_pkg::READING_BITS-1:0] in_reading,
  // one result beat per frame
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [irbd_pkg::ANG_W-1:0] out_ball_angle,
  output logic [irbd_pkg::DIST_W-1:0]       out_distance_estimate,
  output logic                              out_no_signal,
  output logic                              out_saturated,
  // distance numerator write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irbd_pkg::NUM_W-1:0]        cfg_distance_numerator
);

  // Frame flow:
  //   IDLE   reading * (cos, sin) from the sensor table into the running sums
  //   LOAD   latch sums, fold left half plane, take magnitudes, clear sums
  //   SQX/SQY one shared 32x32 multiplier squares |x| then |y|; ADD sums them
  //   CALC   32 root digits; heading CORDIC runs in the first 16 of them
  //   PREP   overflow check of the quotient, divider init
  //   DIV    16 quotient bits
  //   EMIT   load the output register once it is free
  // The output register decouples the result side, so a stalled result does
  // not stop the next frame from accumulating.

  irbd_pkg::dp_cmd_t cmd;
  irbd_pkg::dp_sts_t sts;

  // the user must write the register only between frames (not enforced here); always accept
  assign cfg_ready = 1'b1;

  irbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  irbd_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_reading             (in_reading),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_distance_numerator (cfg_distance_numerator),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_ball_angle         (out_ball_angle),
    .out_distance_estimate  (out_distance_estimate),
    .out_no_signal          (out_no_signal),
    .out_saturated          (out_saturated)
  );

endmodule

// File: hdl/irbd_ctrl.sv
`timescale 1ns / 1ps
`include "ir_ring_ball_direction_macros.svh"
module irbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irbd_pkg::dp_sts_t sts,
  output irbd_pkg::dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_SQX  = 9'b000000100,
    S_SQY  = 9'b000001000,
    S_ADD  = 9'b000010000,
    S_CALC = 9'b000100000,
    S_PREP = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [irbd_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                        accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    iter_nxt   = iter_r;
    cmd        = '0;
    cmd.iter   = iter_r;
    cmd.cordic = (state_r == S_CALC) &&
                 (iter_r < irbd_pkg::ITER_W'(irbd_pkg::CORDIC_STEPS));
    unique case (state_r)
      S_IDLE: begin
        cmd.accum = accept;
        if (accept && sts.last) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add_sq = 1'b1;
        iter_nxt   = '0;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (iter_r == irbd_pkg::ITER_W'(irbd_pkg::SQRT_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = S_PREP;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (iter_r == irbd_pkg::ITER_W'(irbd_pkg::DIV_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  `IRBD_ASSERT_NEXT(a_last_loads, accept && sts.last, state_r == S_LOAD, "frame end not loaded")
  `IRBD_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "emit into busy output")
  `IRBD_ASSERT_NEXT(a_calc_len, state_r == S_CALC && iter_r == irbd_pkg::ITER_W'(irbd_pkg::SQRT_STEPS - 1), state_r == S_PREP, "root pass length wrong")

endmodule

// File: hdl/irbd_datapath.sv
`timescale 1ns / 1ps
`include "ir_ring_ball_direction_macros.svh"
module irbd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  irbd_pkg::dp_cmd_t                   cmd,
  output irbd_pkg::dp_sts_t                   sts,
  input  logic [irbd_pkg::READING_BITS-1:0]   in_reading,
  input  logic                                cfg_we,
  input  logic [irbd_pkg::NUM_W-1:0]          cfg_distance_numerator,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [irbd_pkg::ANG_W-1:0]   out_ball_angle,
  output logic [irbd_pkg::DIST_W-1:0]         out_distance_estimate,
  output logic                                out_no_signal,
  output logic                                out_saturated
);

  localparam logic signed [irbd_pkg::Z_W-1:0] ANG_HI = irbd_pkg::Z_W'(irbd_pkg::ANGLE_MAX);
  localparam logic signed [irbd_pkg::Z_W-1:0] ANG_LO = -ANG_HI;
  localparam logic signed [irbd_pkg::Z_W-1:0] Z_PI   = irbd_pkg::Z_W'(irbd_pkg::Q16_PI);

  // config and frame accumulation
  logic [irbd_pkg::NUM_W-1:0]  num_r;
  logic [irbd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [irbd_pkg::SUM_W-1:0]  sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  irbd_pkg::dir_t              dir;
  logic signed [irbd_pkg::DIR_W-1:0]        dir_c, dir_s;
  logic signed [irbd_pkg::READING_BITS:0]   rd_s;
  logic signed [irbd_pkg::PROD_W-1:0]       prod_x, prod_y;

  // heading CORDIC
  logic signed [irbd_pkg::CV_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, sx_e, sy_e, xs, ys;
  logic signed [irbd_pkg::Z_W-1:0]  z_r, z_nxt, atan_k, ang_sh, ang_cl;
  logic [irbd_pkg::K_W-1:0]         k;

  // length: squares, root, divide
  logic [irbd_pkg::SUM_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, mul_op;
  logic [irbd_pkg::SQ_W-1:0]   mul_res, sqa_r, sqa_nxt, sqb_r, sqb_nxt, rad_r, rad_nxt;
  logic [irbd_pkg::REM_W-1:0]  rem_r, rem_nxt, rem_t, trial;
  logic [irbd_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [irbd_pkg::DREM_W-1:0] drem_r, drem_nxt, dt, dlen;
  logic [irbd_pkg::DIST_W-1:0] q_r, q_nxt;
  logic [irbd_pkg::NUM_W+irbd_pkg::DIV_SHIFT-1:0] num_sh;
  logic zero_r, zero_nxt, sat_r, sat_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [irbd_pkg::ANG_W-1:0]  out_ball_angle_r, out_ball_angle_nxt;
  logic [irbd_pkg::DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic                               out_no_signal_r, out_no_signal_nxt;
  logic                               out_saturated_r, out_saturated_nxt;

  assign dir    = irbd_pkg::DIR_TAB[cnt_r];
  assign dir_c  = dir.c;
  assign dir_s  = dir.s;
  assign rd_s   = {1'b0, in_reading};
  assign prod_x = rd_s * dir_c;
  assign prod_y = rd_s * dir_s;

  assign sx_e   = irbd_pkg::CV_W'($signed(sum_x_r));
  assign sy_e   = irbd_pkg::CV_W'($signed(sum_y_r));
  assign k      = cmd.iter[irbd_pkg::K_W-1:0];
  assign xs     = cx_r >>> k;
  assign ys     = cy_r >>> k;
  assign atan_k = irbd_pkg::Z_W'(irbd_pkg::ATAN_Q16[k]);
  assign ang_sh = (z_r + irbd_pkg::Z_W'(irbd_pkg::ANGLE_ROUND)) >>> irbd_pkg::ANGLE_SHIFT;
  assign ang_cl = (ang_sh > ANG_HI) ? ANG_HI : ((ang_sh < ANG_LO) ? ANG_LO : ang_sh);

  assign mul_op  = cmd.sq_y ? ay_r : ax_r;
  assign mul_res = irbd_pkg::SQ_W'(mul_op) * irbd_pkg::SQ_W'(mul_op);

  // one root digit: bring down two radicand bits, try 4*root+1
  assign rem_t = {rem_r[irbd_pkg::REM_W-3:0], rad_r[irbd_pkg::SQ_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  // one quotient bit; dividend low bits are all zero
  assign dt     = {drem_r[irbd_pkg::ROOT_W-1:0], 1'b0};
  assign dlen   = {1'b0, root_r};
  assign num_sh = {num_r, {irbd_pkg::DIV_SHIFT{1'b0}}};

  assign sts.last     = (cnt_r == irbd_pkg::CNT_W'(irbd_pkg::NUM_SENSORS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    cnt_nxt   = cnt_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    z_nxt     = z_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    zero_nxt  = zero_r;
    sqa_nxt   = sqa_r;
    sqb_nxt   = sqb_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    drem_nxt  = drem_r;
    q_nxt     = q_r;
    sat_nxt   = sat_r;

    if (cmd.accum) begin
      sum_x_nxt = sum_x_r + irbd_pkg::SUM_W'(prod_x);
      sum_y_nxt = sum_y_r + irbd_pkg::SUM_W'(prod_y);
      cnt_nxt   = sts.last ? '0 : cnt_r + 1'b1;
    end

    if (cmd.load) begin
      // fold the left half plane onto the right, +-pi base
      if (sx_e < 0) begin
        cx_nxt = -sx_e;
        cy_nxt = -sy_e;
        z_nxt  = (sy_e >= 0) ? Z_PI : -Z_PI;
      end else begin
        cx_nxt = sx_e;
        cy_nxt = sy_e;
        z_nxt  = '0;
      end
      ax_nxt    = sum_x_r[irbd_pkg::SUM_W-1] ? -sum_x_r : sum_x_r;
      ay_nxt    = sum_y_r[irbd_pkg::SUM_W-1] ? -sum_y_r : sum_y_r;
      zero_nxt  = (sum_x_r == '0) && (sum_y_r == '0);
      sum_x_nxt = '0;
      sum_y_nxt = '0;
    end

    if (cmd.sq_x) begin
      sqa_nxt = mul_res;
    end
    if (cmd.sq_y) begin
      sqb_nxt = mul_res;
    end
    if (cmd.add_sq) begin
      rad_nxt  = sqa_r + sqb_r;
      rem_nxt  = '0;
      root_nxt = '0;
    end

    if (cmd.calc) begin
      rad_nxt = {rad_r[irbd_pkg::SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_r[irbd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_r[irbd_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd.cordic) begin
      if (cy_r > 0) begin
        cx_nxt = cx_r + ys;
        cy_nxt = cy_r - xs;
        z_nxt  = z_r + atan_k;
      end else begin
        cx_nxt = cx_r - ys;
        cy_nxt = cy_r + xs;
        z_nxt  = z_r - atan_k;
      end
    end

    if (cmd.prep) begin
      // quotient overflows 16 bits exactly when num*2^7 >= length
      drem_nxt = irbd_pkg::DREM_W'(num_sh);
      q_nxt    = '0;
      sat_nxt  = zero_r || (irbd_pkg::ROOT_W'(num_sh) >= root_r);
    end

    if (cmd.div) begin
      if (dt >= dlen) begin
        drem_nxt = dt - dlen;
        q_nxt    = {q_r[irbd_pkg::DIST_W-2:0], 1'b1};
      end else begin
        drem_nxt = dt;
        q_nxt    = {q_r[irbd_pkg::DIST_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    out_valid_nxt      = out_valid_r && out_stall;
    out_ball_angle_nxt = out_ball_angle_r;
    out_dist_nxt       = out_dist_r;
    out_no_signal_nxt  = out_no_signal_r;
    out_saturated_nxt  = out_saturated_r;
    if (cmd.emit) begin
      out_valid_nxt      = 1'b1;
      out_ball_angle_nxt = zero_r ? '0 : irbd_pkg::ANG_W'(ang_cl);
      out_dist_nxt       = sat_r ? '1 : q_r;
      out_no_signal_nxt  = zero_r;
      out_saturated_nxt  = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= irbd_pkg::NUM_RESET;
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_r <= cfg_distance_numerator;
      end
      cnt_r       <= cnt_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r             <= cx_nxt;
    cy_r             <= cy_nxt;
    z_r              <= z_nxt;
    ax_r             <= ax_nxt;
    ay_r             <= ay_nxt;
    zero_r           <= zero_nxt;
    sqa_r            <= sqa_nxt;
    sqb_r            <= sqb_nxt;
    rad_r            <= rad_nxt;
    rem_r            <= rem_nxt;
    root_r           <= root_nxt;
    drem_r           <= drem_nxt;
    q_r              <= q_nxt;
    sat_r            <= sat_nxt;
    out_ball_angle_r <= out_ball_angle_nxt;
    out_dist_r       <= out_dist_nxt;
    out_no_signal_r  <= out_no_signal_nxt;
    out_saturated_r  <= out_saturated_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_ball_angle        = out_ball_angle_r;
  assign out_distance_estimate = out_dist_r;
  assign out_no_signal         = out_no_signal_r;
  assign out_saturated         = out_saturated_r;

  `IRBD_ASSERT(a_nosig_sat, out_valid_r && out_no_signal_r |-> out_saturated_r && out_ball_angle_r == '0 && out_dist_r == '1, "empty frame result malformed")
  `IRBD_ASSERT(a_ang_range, out_valid_r |-> $signed(out_ball_angle_r) <= irbd_pkg::ANGLE_MAX && $signed(out_ball_angle_r) >= -irbd_pkg::ANGLE_MAX, "heading out of range")
  `IRBD_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_dist_r) && $stable(out_ball_angle_r), "stalled result beat changed")

endmodule
